### design/sidta_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidta_pkg
// Shared types and constants for the signed integer to decimal ASCII core.
// ----------------------------------------------------------------------------

package sidta_pkg;

	localparam int CHAR_W  = 6;
	localparam int DIGIT_W = 4;

	localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 6'd48;
	localparam logic [CHAR_W-1:0]  ASCII_MINUS = 6'd45;
	localparam logic [DIGIT_W-1:0] BCD_LIMIT   = 4'd5;
	localparam logic [DIGIT_W-1:0] BCD_ADJUST  = 4'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONVERT,
		ST_SIGN,
		ST_SKIP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic skip_digit;
		logic emit_sign;
		logic emit_digit;
	} cmd_t;

	typedef struct packed {
		logic step_done;
		logic negative;
		logic top_zero;
		logic last_digit;
		logic out_free;
	} status_t;

endpackage

### design/sidta_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidta_dp
// Datapath: magnitude register, double dabble BCD register, digit shifter
// and output character register.
// ----------------------------------------------------------------------------

module sidta_dp #(
	parameter int VALUE_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic signed [VALUE_BITS-1:0]  value,
	input  sidta_pkg::cmd_t               cmd,
	output sidta_pkg::status_t            status,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [sidta_pkg::CHAR_W-1:0]  text_char,
	output logic                          is_last
);

	localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
	localparam int BCD_W      = NUM_DIGITS * sidta_pkg::DIGIT_W;
	localparam int STEP_W     = $clog2(VALUE_BITS);
	localparam int DCNT_W     = $clog2(NUM_DIGITS);

	logic [VALUE_BITS-1:0]             mag_q;
	logic [BCD_W-1:0]                  bcd_q;
	logic                              neg_q;
	logic [STEP_W-1:0]                 step_cnt_q;
	logic [DCNT_W-1:0]                 digit_cnt_q;
	logic                              out_valid_q;
	logic [sidta_pkg::CHAR_W-1:0]      text_char_q;
	logic                              is_last_q;

	logic [BCD_W-1:0]                  bcd_adj;
	logic [sidta_pkg::DIGIT_W-1:0]     top_digit;
	logic                              out_free;

	always_comb begin
		for (int d = 0; d < NUM_DIGITS; d++) begin
			if (bcd_q[d*sidta_pkg::DIGIT_W +: sidta_pkg::DIGIT_W] >= sidta_pkg::BCD_LIMIT) begin
				bcd_adj[d*sidta_pkg::DIGIT_W +: sidta_pkg::DIGIT_W] =
					bcd_q[d*sidta_pkg::DIGIT_W +: sidta_pkg::DIGIT_W] + sidta_pkg::BCD_ADJUST;
			end else begin
				bcd_adj[d*sidta_pkg::DIGIT_W +: sidta_pkg::DIGIT_W] =
					bcd_q[d*sidta_pkg::DIGIT_W +: sidta_pkg::DIGIT_W];
			end
		end
	end

	assign top_digit = bcd_q[BCD_W-1 -: sidta_pkg::DIGIT_W];
	assign out_free  = !out_valid_q || !out_stall;

	assign status.step_done  = (step_cnt_q == '0);
	assign status.negative   = neg_q;
	assign status.top_zero   = (top_digit == '0);
	assign status.last_digit = (digit_cnt_q == '0);
	assign status.out_free   = out_free;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q       <= value[VALUE_BITS-1] ? (-value) : value;
			bcd_q       <= '0;
			step_cnt_q  <= STEP_W'(VALUE_BITS - 1);
			digit_cnt_q <= DCNT_W'(NUM_DIGITS - 1);
		end else if (cmd.step) begin
			mag_q      <= {mag_q[VALUE_BITS-2:0], 1'b0};
			bcd_q      <= {bcd_adj[BCD_W-2:0], mag_q[VALUE_BITS-1]};
			step_cnt_q <= step_cnt_q - 1'b1;
		end else if (cmd.skip_digit || cmd.emit_digit) begin
			bcd_q       <= {bcd_q[BCD_W-sidta_pkg::DIGIT_W-1:0], {sidta_pkg::DIGIT_W{1'b0}}};
			digit_cnt_q <= digit_cnt_q - 1'b1;
		end
		if (cmd.emit_sign) begin
			text_char_q <= sidta_pkg::ASCII_MINUS;
			is_last_q   <= 1'b0;
		end else if (cmd.emit_digit) begin
			text_char_q <= sidta_pkg::ASCII_ZERO +
				{{(sidta_pkg::CHAR_W-sidta_pkg::DIGIT_W){1'b0}}, top_digit};
			is_last_q   <= status.last_digit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neg_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				neg_q <= value[VALUE_BITS-1];
			end
			if (cmd.emit_sign || cmd.emit_digit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign text_char = text_char_q;
	assign is_last   = is_last_q;

endmodule

### design/sidta_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidta_ctrl
// Controller: sequences load, conversion steps, sign, leading zero skip and
// digit transfers.
// ----------------------------------------------------------------------------

module sidta_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  sidta_pkg::status_t   status,
	output sidta_pkg::cmd_t      cmd
);

	sidta_pkg::state_t state_q;
	sidta_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sidta_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		case (state_q)
			sidta_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = sidta_pkg::ST_CONVERT;
				end
			end
			sidta_pkg::ST_CONVERT: begin
				cmd.step = 1'b1;
				if (status.step_done) begin
					state_nxt = status.negative ? sidta_pkg::ST_SIGN : sidta_pkg::ST_SKIP;
				end
			end
			sidta_pkg::ST_SIGN: begin
				if (status.out_free) begin
					cmd.emit_sign = 1'b1;
					state_nxt     = sidta_pkg::ST_SKIP;
				end
			end
			sidta_pkg::ST_SKIP: begin
				if (status.top_zero && !status.last_digit) begin
					cmd.skip_digit = 1'b1;
				end else begin
					state_nxt = sidta_pkg::ST_EMIT;
				end
			end
			sidta_pkg::ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit_digit = 1'b1;
					if (status.last_digit) begin
						state_nxt = sidta_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_nxt = sidta_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### design/signed_int_to_decimal_ascii_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core
// Converts a signed integer to its decimal ASCII text, one character per
// transfer, most significant first, last character flagged.
// ----------------------------------------------------------------------------
// sequence: the input transfer loads the value, the shift-and-adjust loop takes
// a single bit per cycle, a negative value emits a minus sign, leading zero digits
// are skipped, the remaining digits are emitted, output stalls hold each emit
// one item at a time: no new input is accepted until the last digit is emitted
// reset: arst_n clears the controller state, sign flag and output valid asynchronously

module signed_int_to_decimal_ascii_core #(
	parameter int VALUE_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [VALUE_BITS-1:0]  value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [sidta_pkg::CHAR_W-1:0]  text_char,
	output logic                          is_last
);

	sidta_pkg::cmd_t    cmd;
	sidta_pkg::status_t status;

	sidta_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	sidta_dp #(
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (value),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.text_char (text_char),
		.is_last   (is_last)
	);

endmodule
